// File: rtl/core/sbps_pkg.sv
// shared types, constants and saturation helpers for the swept box physics step
`default_nettype none

package sbps_pkg;

    // body table size and derived widths
    localparam int C_MAX_BODIES = 16;
    localparam int C_IDX_W      = $clog2(C_MAX_BODIES);
    localparam int C_CNT_W      = $clog2(C_MAX_BODIES + 1);

    // field widths
    localparam int C_POS_W  = 16;
    localparam int C_SIZE_W = 12;
    // working width for sums of positions, sizes and velocity magnitudes
    localparam int C_EW     = C_POS_W + 3;

    // operation codes of an input beat
    localparam logic C_OP_LOAD = 1'b0;
    localparam logic C_OP_TICK = 1'b1;

    // configuration register indexes
    localparam logic C_REG_BODY_COUNT = 1'b0;

    typedef logic signed [C_POS_W-1:0] t_coord;
    typedef logic signed [C_EW-1:0]    t_wide;

    // one stored body
    typedef struct packed {
        logic signed [C_POS_W-1:0] pos_x;
        logic signed [C_POS_W-1:0] pos_y;
        logic [C_SIZE_W-1:0]       size_w;
        logic [C_SIZE_W-1:0]       size_h;
        logic signed [C_POS_W-1:0] vel_x;
        logic signed [C_POS_W-1:0] vel_y;
        logic signed [C_POS_W-1:0] acc_x;
        logic signed [C_POS_W-1:0] acc_y;
        logic                      gravity;
    } t_body;

    // sign extend a coordinate to working width
    function automatic t_wide sx(input t_coord v);
        return t_wide'(v);
    endfunction

    // zero extend a size to working width
    function automatic t_wide zx(input logic [C_SIZE_W-1:0] v);
        return t_wide'(v);
    endfunction

    // saturate a working value to the coordinate range
    function automatic t_coord sat16(input t_wide v);
        t_coord r;
        if (v > t_wide'(32767)) begin
            r = 16'sh7fff;
        end else if (v < -t_wide'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[C_POS_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/sbps_pair.sv
// swept overlap test of the current body against one later body, with velocity clamp
`default_nettype none

module sbps_pair
    import sbps_pkg::*;
(
    input  wire t_body  i_cur,
    input  wire t_coord i_vx,
    input  wire t_coord i_vy,
    input  wire t_body  i_other,
    output t_coord      o_vx,
    output t_coord      o_vy
);

    t_wide w_px, w_py, w_pw, w_ph;
    t_wide w_qx, w_qy, w_qw, w_qh;
    t_wide w_vx, w_vy, w_ax, w_ay;
    t_wide w_lo_x, w_hi_x, w_lo_y, w_hi_y;
    t_wide w_ps_x, w_ps_y, w_qt_x, w_qt_y;
    logic  w_filled;
    logic  w_hit;
    t_coord w_cx, w_cy;

    // operands at working width
    assign w_px = sx(i_cur.pos_x);
    assign w_py = sx(i_cur.pos_y);
    assign w_pw = zx(i_cur.size_w);
    assign w_ph = zx(i_cur.size_h);
    assign w_qx = sx(i_other.pos_x);
    assign w_qy = sx(i_other.pos_y);
    assign w_qw = zx(i_other.size_w);
    assign w_qh = zx(i_other.size_h);
    assign w_vx = sx(i_vx);
    assign w_vy = sx(i_vy);

    // velocity magnitudes
    assign w_ax = w_vx[C_EW-1] ? -w_vx : w_vx;
    assign w_ay = w_vy[C_EW-1] ? -w_vy : w_vy;

    // swept box edges
    assign w_lo_x = w_px - w_ax;
    assign w_hi_x = w_px + w_pw + w_ax;
    assign w_lo_y = w_py - w_ay;
    assign w_hi_y = w_py + w_ph + w_ay;

    // far edges of both unswept boxes
    assign w_ps_x = w_px + w_pw;
    assign w_ps_y = w_py + w_ph;
    assign w_qt_x = w_qx + w_qw;
    assign w_qt_y = w_qy + w_qh;

    // empty boxes never overlap; the current box counts as filled on an axis where it moves
    assign w_filled = ((i_cur.size_w != '0) || (i_vx != '0))
                   && ((i_cur.size_h != '0) || (i_vy != '0))
                   && (i_other.size_w != '0) && (i_other.size_h != '0);

    // strict overlap
    assign w_hit = w_filled && (w_lo_x < w_qt_x) && (w_qx < w_hi_x)
                && (w_lo_y < w_qt_y) && (w_qy < w_hi_y);

    // clamp each axis to the gap toward a separated neighbour
    always_comb begin
        w_cx = i_vx;
        if (!i_vx[C_POS_W-1] && (i_vx != '0) && (w_ps_x <= w_qx)) begin
            w_cx = sat16(w_qx - w_ps_x);
        end else if (i_vx[C_POS_W-1] && (w_qt_x <= w_px)) begin
            w_cx = sat16(w_qt_x - w_px);
        end
        w_cy = i_vy;
        if (!i_vy[C_POS_W-1] && (i_vy != '0) && (w_ps_y <= w_qy)) begin
            w_cy = sat16(w_qy - w_ps_y);
        end else if (i_vy[C_POS_W-1] && (w_qt_y <= w_py)) begin
            w_cy = sat16(w_qt_y - w_py);
        end
    end

    assign o_vx = w_hit ? w_cx : i_vx;
    assign o_vy = w_hit ? w_cy : i_vy;

endmodule

`default_nettype wire

// File: rtl/core/swept_box_physics_step.sv
// top level: body table, tick sequencer, config register and result register
//
// Input channel (i_in_valid / o_in_ready) takes one beat per item. A load beat
// (operation 0) writes one body into the table in the cycle it is accepted and
// gives no result. A tick beat (operation 1) visits bodies 0 .. n-1, where n is
// body_count capped at 16, and gives one result beat per body on the output
// channel (o_out_valid / i_out_ready), last_body marking the final one.
// A tick with n of zero gives no result and finishes at once.
// Per body the sequencer goes through the table read, the velocity update,
// one step per later body in the pair checker, the move and write back, and
// a state that holds the result until it is taken. The pair loop runs on the
// single shared checker.
// The block takes a new input beat only when idle. A stalled receiver holds
// the result register and the sequencer waits on it.
// Reset clears the sequencer and body_count; the table holds whatever was last
// loaded and must be loaded before a tick uses it.
// body_count is written over the APB-style port at byte address 0.
`default_nettype none

module swept_box_physics_step
    import sbps_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    // configuration port
    input  wire                      psel,
    input  wire                      penable,
    input  wire                      pwrite,
    input  wire [2:0]                paddr,
    input  wire [31:0]               pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    // input channel
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire                      i_operation,
    input  wire [3:0]                i_body_index,
    input  wire signed [15:0]        i_pos_x,
    input  wire signed [15:0]        i_pos_y,
    input  wire [11:0]               i_box_w,
    input  wire [11:0]               i_box_h,
    input  wire signed [15:0]        i_vel_x,
    input  wire signed [15:0]        i_vel_y,
    input  wire signed [15:0]        i_acc_x,
    input  wire signed [15:0]        i_acc_y,
    input  wire                      i_has_gravity,
    // output channel
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output logic [3:0]               o_out_index,
    output logic signed [15:0]       o_new_x,
    output logic signed [15:0]       o_new_y,
    output logic signed [15:0]       o_new_vel_x,
    output logic signed [15:0]       o_new_vel_y,
    output logic                     o_last_body
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_INIT,
        S_PAIR,
        S_MOVE,
        S_OUT
    } t_state;

    t_state               r_state;
    logic [C_CNT_W-1:0]   r_body_count;
    logic [C_CNT_W-1:0]   r_n;
    logic [C_CNT_W-1:0]   r_i;
    logic [C_CNT_W-1:0]   r_j;
    t_body                r_cur;
    t_coord               r_vx;
    t_coord               r_vy;
    t_body                r_rd_a;
    t_body                r_rd_b;
    t_body                r_mem [C_MAX_BODIES];

    logic                 w_cfg_wr;
    logic                 w_in_fire;
    logic [C_CNT_W-1:0]   w_n;
    logic [C_CNT_W-1:0]   w_addr_b;
    logic [C_CNT_W-1:0]   w_i_inc;
    logic [C_CNT_W-1:0]   w_j_inc;
    t_coord               w_sum_vx;
    t_coord               w_sum_vy;
    t_coord               w_pair_vx;
    t_coord               w_pair_vy;
    t_coord               w_new_x;
    t_coord               w_new_y;
    logic                 w_we;
    logic [C_IDX_W-1:0]   w_waddr;
    t_body                w_wdata;

    // configuration register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == C_REG_BODY_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body_count <= '0;
        end else if (w_cfg_wr) begin
            r_body_count <= pwdata[C_CNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == C_REG_BODY_COUNT) begin
            prdata = 32'(r_body_count);
        end
    end

    // handshake and small counters
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_n        = (r_body_count > C_CNT_W'(C_MAX_BODIES))
                      ? C_CNT_W'(C_MAX_BODIES) : r_body_count;
    assign w_i_inc    = r_i + C_CNT_W'(1);
    assign w_j_inc    = r_j + C_CNT_W'(1);
    assign w_addr_b   = (r_state == S_PAIR) ? w_j_inc : r_j;

    // velocity update from the fetched body
    assign w_sum_vx = sat16(sx(r_rd_a.vel_x) + sx(r_rd_a.acc_x));
    assign w_sum_vy = sat16(sx(r_rd_a.vel_y) + sx(r_rd_a.acc_y) + t_wide'(r_rd_a.gravity));

    // move by the clamped velocity
    assign w_new_x = sat16(sx(r_cur.pos_x) + sx(r_vx));
    assign w_new_y = sat16(sx(r_cur.pos_y) + sx(r_vy));

    // shared pair checker
    sbps_pair u_pair (
        .i_cur   (r_cur),
        .i_vx    (r_vx),
        .i_vy    (r_vy),
        .i_other (r_rd_b),
        .o_vx    (w_pair_vx),
        .o_vy    (w_pair_vy)
    );

    // table write port: loads when idle, write back after the move
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_i[C_IDX_W-1:0];
        w_wdata = r_cur;
        if (r_state == S_MOVE) begin
            w_we          = 1'b1;
            w_wdata.pos_x = w_new_x;
            w_wdata.pos_y = w_new_y;
            w_wdata.vel_x = r_vx;
            w_wdata.vel_y = r_vy;
        end else if (w_in_fire && (i_operation == C_OP_LOAD)
                     && ({1'b0, i_body_index} < C_CNT_W'(C_MAX_BODIES))) begin
            w_we            = 1'b1;
            w_waddr         = i_body_index[C_IDX_W-1:0];
            w_wdata.pos_x   = i_pos_x;
            w_wdata.pos_y   = i_pos_y;
            w_wdata.size_w  = i_box_w;
            w_wdata.size_h  = i_box_h;
            w_wdata.vel_x   = i_vel_x;
            w_wdata.vel_y   = i_vel_y;
            w_wdata.acc_x   = i_acc_x;
            w_wdata.acc_y   = i_acc_y;
            w_wdata.gravity = i_has_gravity;
        end
    end

    // body table: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_a <= r_mem[r_i[C_IDX_W-1:0]];
        r_rd_b <= r_mem[w_addr_b[C_IDX_W-1:0]];
    end

    // tick sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire && (i_operation == C_OP_TICK) && (w_n != '0)) begin
                        r_n     <= w_n;
                        r_i     <= '0;
                        r_j     <= C_CNT_W'(1);
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_state <= S_INIT;
                end
                S_INIT: begin
                    r_cur <= r_rd_a;
                    r_vx  <= w_sum_vx;
                    r_vy  <= w_sum_vy;
                    if (r_j == r_n) begin
                        r_state <= S_MOVE;
                    end else begin
                        r_state <= S_PAIR;
                    end
                end
                S_PAIR: begin
                    r_vx <= w_pair_vx;
                    r_vy <= w_pair_vy;
                    r_j  <= w_j_inc;
                    if (w_j_inc == r_n) begin
                        r_state <= S_MOVE;
                    end
                end
                S_MOVE: begin
                    o_out_valid <= 1'b1;
                    o_out_index <= r_i[3:0];
                    o_new_x     <= w_new_x;
                    o_new_y     <= w_new_y;
                    o_new_vel_x <= r_vx;
                    o_new_vel_y <= r_vy;
                    o_last_body <= (w_i_inc == r_n);
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        o_out_valid <= 1'b0;
                        if (w_i_inc == r_n) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= w_i_inc;
                            r_j     <= w_i_inc + C_CNT_W'(1);
                            r_state <= S_FETCH;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: bench/tb_swept_box_physics_step.sv
// self-checking testbench for the swept box physics step: directed table, then random phases
`default_nettype none

module tb_swept_box_physics_step;
    timeunit 1ns;
    timeprecision 1ps;

    import sbps_pkg::*;

    // one input beat as the bench sees it
    typedef struct {
        logic         op;
        logic [3:0]   idx;
        t_coord       px;
        t_coord       py;
        logic [11:0]  w;
        logic [11:0]  h;
        t_coord       vx;
        t_coord       vy;
        t_coord       ax;
        t_coord       ay;
        logic         grav;
    } t_body_beat;

    // one reported body
    typedef struct {
        logic [3:0]   idx;
        t_coord       x;
        t_coord       y;
        t_coord       vx;
        t_coord       vy;
        logic         last;
    } t_body_report;

    typedef enum {ROW_CONFIG, ROW_BEAT} t_row_kind;

    typedef struct {
        t_row_kind    kind;
        int unsigned  count;
        t_body_beat   beat;
        bit           typed;
        t_body_report rep;
    } t_dir_row;

    localparam int C_HOLD_CYCLES = 300;
    localparam int C_RAND_BEATS  = 450;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_operation;
    logic [3:0]         i_body_index;
    logic signed [15:0] i_pos_x;
    logic signed [15:0] i_pos_y;
    logic [11:0]        i_box_w;
    logic [11:0]        i_box_h;
    logic signed [15:0] i_vel_x;
    logic signed [15:0] i_vel_y;
    logic signed [15:0] i_acc_x;
    logic signed [15:0] i_acc_y;
    logic               i_has_gravity;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [3:0]         o_out_index;
    logic signed [15:0] o_new_x;
    logic signed [15:0] o_new_y;
    logic signed [15:0] o_new_vel_x;
    logic signed [15:0] o_new_vel_y;
    logic               o_last_body;

    swept_box_physics_step u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_body_index  (i_body_index),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_box_w       (i_box_w),
        .i_box_h       (i_box_h),
        .i_vel_x       (i_vel_x),
        .i_vel_y       (i_vel_y),
        .i_acc_x       (i_acc_x),
        .i_acc_y       (i_acc_y),
        .i_has_gravity (i_has_gravity),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_index   (o_out_index),
        .o_new_x       (o_new_x),
        .o_new_y       (o_new_y),
        .o_new_vel_x   (o_new_vel_x),
        .o_new_vel_y   (o_new_vel_y),
        .o_last_body   (o_last_body)
    );

    // shadow body table and register
    t_coord       tbl_x  [C_MAX_BODIES];
    t_coord       tbl_y  [C_MAX_BODIES];
    logic [11:0]  tbl_w  [C_MAX_BODIES];
    logic [11:0]  tbl_h  [C_MAX_BODIES];
    t_coord       tbl_vx [C_MAX_BODIES];
    t_coord       tbl_vy [C_MAX_BODIES];
    t_coord       tbl_ax [C_MAX_BODIES];
    t_coord       tbl_ay [C_MAX_BODIES];
    logic         tbl_g  [C_MAX_BODIES];
    logic [4:0]   body_count_shadow = '0;

    t_body_report tick_reports[$];
    t_body_report pending_reports[$];
    t_dir_row     dir_rows[$];

    int           errors = 0;
    int           reports_seen = 0;
    bit           hold_request = 1'b0;

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #8_000_000;
        $display("swept_box_physics_step test failed");
        $finish;
    end

    function automatic t_coord clip16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return t_coord'(v);
    endfunction

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // strict overlap of body a swept by (vx, vy) against body b at rest
    function automatic bit boxes_touch(input int a, input int b, input longint vx,
                                       input longint vy);
        longint ax, ay, aw, ah, bx, by, bw, bh;
        ax = longint'(tbl_x[a]) - mag(vx);
        ay = longint'(tbl_y[a]) - mag(vy);
        aw = longint'(tbl_w[a]) + 2 * mag(vx);
        ah = longint'(tbl_h[a]) + 2 * mag(vy);
        bx = longint'(tbl_x[b]);
        by = longint'(tbl_y[b]);
        bw = longint'(tbl_w[b]);
        bh = longint'(tbl_h[b]);
        if (aw <= 0 || ah <= 0 || bw <= 0 || bh <= 0) return 1'b0;
        return (ax < bx + bw) && (bx < ax + aw) && (ay < by + bh) && (by < ay + ah);
    endfunction

    // velocity toward a separated neighbour becomes the signed gap
    function automatic t_coord gap_clamp(input t_coord v, input longint p, input longint s,
                                         input longint q, input longint t);
        if (v > 0 && p + s <= q) return clip16(q - (p + s));
        if (v < 0 && q + t <= p) return clip16(-(p - (q + t)));
        return v;
    endfunction

    function automatic void load_body(input t_body_beat b);
        tbl_x[b.idx]  = b.px;
        tbl_y[b.idx]  = b.py;
        tbl_w[b.idx]  = b.w;
        tbl_h[b.idx]  = b.h;
        tbl_vx[b.idx] = b.vx;
        tbl_vy[b.idx] = b.vy;
        tbl_ax[b.idx] = b.ax;
        tbl_ay[b.idx] = b.ay;
        tbl_g[b.idx]  = b.grav;
    endfunction

    // one physics tick over the shadow table, reports into tick_reports
    function automatic void tick_bodies();
        int n;
        t_coord vx, vy, nx, ny;
        t_body_report r;
        tick_reports.delete();
        n = (body_count_shadow > C_MAX_BODIES) ? C_MAX_BODIES : int'(body_count_shadow);
        for (int i = 0; i < n; i++) begin
            vx = clip16(longint'(tbl_vx[i]) + longint'(tbl_ax[i]));
            vy = clip16(longint'(tbl_vy[i]) + longint'(tbl_ay[i]) + longint'(tbl_g[i]));
            for (int j = i + 1; j < n; j++) begin
                if (boxes_touch(i, j, vx, vy)) begin
                    nx = gap_clamp(vx, tbl_x[i], tbl_w[i], tbl_x[j], tbl_w[j]);
                    ny = gap_clamp(vy, tbl_y[i], tbl_h[i], tbl_y[j], tbl_h[j]);
                    vx = nx;
                    vy = ny;
                end
            end
            tbl_vx[i] = vx;
            tbl_vy[i] = vy;
            tbl_x[i]  = clip16(longint'(tbl_x[i]) + longint'(vx));
            tbl_y[i]  = clip16(longint'(tbl_y[i]) + longint'(vy));
            r.idx  = 4'(i);
            r.x    = tbl_x[i];
            r.y    = tbl_y[i];
            r.vx   = vx;
            r.vy   = vy;
            r.last = (i + 1 == n);
            tick_reports = {tick_reports, r};
        end
    endfunction

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", name, want, got);
            errors++;
        end
    endfunction

    // directed row builders
    function automatic t_dir_row ld(input int idx, input int px, input int py, input int w,
                                    input int h, input int vx, input int vy, input int ax,
                                    input int ay, input int g);
        t_dir_row r;
        r.kind       = ROW_BEAT;
        r.count      = 0;
        r.typed      = 1'b0;
        r.rep        = '{default: '0};
        r.beat.op    = C_OP_LOAD;
        r.beat.idx   = 4'(idx);
        r.beat.px    = t_coord'(px);
        r.beat.py    = t_coord'(py);
        r.beat.w     = 12'(w);
        r.beat.h     = 12'(h);
        r.beat.vx    = t_coord'(vx);
        r.beat.vy    = t_coord'(vy);
        r.beat.ax    = t_coord'(ax);
        r.beat.ay    = t_coord'(ay);
        r.beat.grav  = 1'(g);
        return r;
    endfunction

    function automatic t_dir_row tk();
        t_dir_row r;
        r = ld(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        r.beat.op = C_OP_TICK;
        return r;
    endfunction

    // single-body tick with its report written out by hand
    function automatic t_dir_row tk_exp(input int x, input int y, input int vx, input int vy);
        t_dir_row r;
        r = tk();
        r.typed = 1'b1;
        r.rep   = '{idx: 4'd0, x: t_coord'(x), y: t_coord'(y), vx: t_coord'(vx),
                    vy: t_coord'(vy), last: 1'b1};
        return r;
    endfunction

    function automatic t_dir_row cfg_row(input int unsigned count);
        t_dir_row r;
        r = tk();
        r.kind  = ROW_CONFIG;
        r.count = count;
        return r;
    endfunction

    // append one row to the directed table
    function automatic void add_row(input t_dir_row r);
        dir_rows = {dir_rows, r};
    endfunction

    function automatic t_coord pick_extreme();
        case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            default: return 16'shffff;
        endcase
    endfunction

    // random body: mostly a crowded neighbourhood, sometimes full range, extremes or an empty box
    function automatic t_body_beat rand_body(input int idx);
        t_body_beat b;
        int mode;
        mode   = $urandom_range(0, 9);
        b.op   = C_OP_LOAD;
        b.idx  = 4'(idx);
        b.grav = 1'($urandom_range(0, 1));
        if (mode <= 6) begin
            b.px = t_coord'(int'($urandom_range(0, 400)) - 200);
            b.py = t_coord'(int'($urandom_range(0, 400)) - 200);
            b.w  = 12'($urandom_range(0, 60));
            b.h  = 12'($urandom_range(0, 60));
            b.vx = t_coord'(int'($urandom_range(0, 80)) - 40);
            b.vy = t_coord'(int'($urandom_range(0, 80)) - 40);
            b.ax = t_coord'(int'($urandom_range(0, 6)) - 3);
            b.ay = t_coord'(int'($urandom_range(0, 6)) - 3);
        end else if (mode == 7) begin
            b.px = t_coord'($urandom);
            b.py = t_coord'($urandom);
            b.w  = 12'($urandom);
            b.h  = 12'($urandom);
            b.vx = t_coord'($urandom);
            b.vy = t_coord'($urandom);
            b.ax = t_coord'($urandom);
            b.ay = t_coord'($urandom);
        end else if (mode == 8) begin
            b.px = pick_extreme();
            b.py = pick_extreme();
            b.w  = ($urandom_range(0, 1) != 0) ? 12'hfff : 12'h000;
            b.h  = ($urandom_range(0, 1) != 0) ? 12'hfff : 12'h001;
            b.vx = pick_extreme();
            b.vy = pick_extreme();
            b.ax = pick_extreme();
            b.ay = pick_extreme();
        end else begin
            // empty box, possibly at rest
            b.px = t_coord'(int'($urandom_range(0, 100)) - 50);
            b.py = t_coord'(int'($urandom_range(0, 100)) - 50);
            b.w  = ($urandom_range(0, 1) != 0) ? 12'h000 : 12'($urandom_range(1, 20));
            b.h  = (b.w != 0) ? 12'h000 : 12'($urandom_range(0, 20));
            b.vx = ($urandom_range(0, 1) != 0) ? 16'sh0000
                                               : t_coord'(int'($urandom_range(0, 20)) - 10);
            b.vy = ($urandom_range(0, 1) != 0) ? 16'sh0000
                                               : t_coord'(int'($urandom_range(0, 20)) - 10);
            b.ax = '0;
            b.ay = '0;
            b.grav = 1'b0;
        end
        return b;
    endfunction

    // offer one beat after a gap, then predict on acceptance
    task automatic send_beat(input t_body_beat b, input int gap, input bit typed,
                             input t_body_report rep);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= b.op;
        i_body_index  <= b.idx;
        i_pos_x       <= b.px;
        i_pos_y       <= b.py;
        i_box_w       <= b.w;
        i_box_h       <= b.h;
        i_vel_x       <= b.vx;
        i_vel_y       <= b.vy;
        i_acc_x       <= b.ax;
        i_acc_y       <= b.ay;
        i_has_gravity <= b.grav;
        do @(posedge i_clk); while (!o_in_ready);
        if (b.op == C_OP_LOAD) begin
            load_body(b);
        end else begin
            tick_bodies();
            if (typed) begin
                pending_reports = {pending_reports, rep};
            end else begin
                pending_reports = {pending_reports, tick_reports};
            end
        end
    endtask

    // drop valid and wait for the block to drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    // write body_count, then read it straight back
    task automatic write_body_count(input int unsigned count);
        logic [4:0] code;
        code    = 5'(count);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * C_REG_BODY_COUNT);
        pwdata  <= {27'($urandom), code};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        body_count_shadow = code;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(body_count_shadow)) begin
            $error("body_count expected %0d got %0d", body_count_shadow, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // stimulus
    initial begin
        t_body_beat   b;
        t_body_report none;
        int           sent;
        int           phase;
        int           beats;
        int           count;
        bit           burst;
        bit           quiet;

        none          = '{default: '0};
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_in_valid    <= 1'b0;
        i_operation   <= C_OP_LOAD;
        i_body_index  <= '0;
        i_pos_x       <= '0;
        i_pos_y       <= '0;
        i_box_w       <= '0;
        i_box_h       <= '0;
        i_vel_x       <= '0;
        i_vel_y       <= '0;
        i_acc_x       <= '0;
        i_acc_y       <= '0;
        i_has_gravity <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        add_row(tk());                                    // empty tick straight after reset
        add_row(ld(0, 0, 0, 10, 10, 5, 0, 0, 0, 0));
        add_row(cfg_row(1));
        add_row(tk_exp(5, 0, 5, 0));
        // saturation of velocity and position at the top and bottom of range
        add_row(ld(0, 32767, -32768, 4095, 0, 32767, -32768, 32767, -32768, 1));
        add_row(tk_exp(32767, -32768, 32767, -32768));
        add_row(ld(0, -32768, 32767, 0, 4095, -32768, 32767, -1, 0, 1));
        add_row(tk_exp(-32768, 32767, -32768, 32767));
        // clamp toward a neighbour on the right
        add_row(ld(0, 0, 0, 10, 10, 20, 0, 0, 0, 0));
        add_row(ld(1, 25, 0, 10, 10, 0, 0, 0, 0, 0));
        add_row(cfg_row(2));
        add_row(tk());
        // moving left exactly onto a neighbour's edge: no strict overlap, so no clamp
        add_row(ld(0, 100, 0, 10, 10, -50, 0, 0, 0, 0));
        add_row(ld(1, 30, 0, 20, 10, 0, 0, 0, 0, 0));
        add_row(tk());
        // falling under gravity onto a neighbour below
        add_row(ld(0, 0, 0, 10, 10, 0, 30, 0, 0, 1));
        add_row(ld(1, 0, 35, 10, 10, 0, 0, 0, 0, 0));
        add_row(tk());
        // neighbour of zero width is never hit
        add_row(ld(1, 25, 0, 0, 10, 0, 0, 0, 0, 0));
        add_row(tk());
        // empty box at rest never hits
        add_row(ld(0, 5, 5, 0, 0, 0, 0, 0, 0, 0));
        add_row(ld(1, 0, 0, 20, 20, -7, 3, 1, -1, 1));
        add_row(tk());

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CONFIG) begin
                wait_idle();
                write_body_count(dir_rows[r].count);
            end else begin
                send_beat(dir_rows[r].beat, $urandom_range(0, 19), dir_rows[r].typed,
                          dir_rows[r].rep);
            end
        end

        // fill the whole table before any larger count is used
        sent = 0;
        for (int k = 0; k < C_MAX_BODIES; k++) begin
            send_beat(rand_body(k), $urandom_range(0, 19), 1'b0, none);
            sent++;
        end

        // random phases, each behind a register write on an idle block
        phase = 0;
        while (sent < C_RAND_BEATS) begin
            case (phase)
                0: count = 16;
                1: count = 0;
                2: count = 31;
                3: count = 17;
                4: count = 1;
                default: count = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 31)
                                                              : $urandom_range(0, 16);
            endcase
            wait_idle();
            write_body_count(count);
            burst = (phase == 0);
            quiet = (phase % 5 == 2);
            if (burst) hold_request = 1'b1;
            beats = $urandom_range(5, 25);
            for (int k = 0; k < beats; k++) begin
                if ((burst && k == 0) || $urandom_range(0, 99) < 35) begin
                    b = rand_body($urandom_range(0, C_MAX_BODIES - 1));
                    b.op = C_OP_TICK;
                end else begin
                    b = rand_body($urandom_range(0, C_MAX_BODIES - 1));
                end
                send_beat(b, (burst || quiet) ? 0 : $urandom_range(0, 19), 1'b0, none);
                sent++;
            end
            phase++;
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending_reports.size() == 0) begin
            $display("swept_box_physics_step test passed");
        end else begin
            $display("swept_box_physics_step test failed");
        end
        $finish;
    end

    // result side: random stalls, one long hold-off, quiet stretches
    initial begin
        t_body_report want;
        int           stall;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = ((reports_seen / 32) % 4 == 3) ? 0 : $urandom_range(0, 19);
            if (hold_request) begin
                stall        = C_HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            reports_seen++;
            if (pending_reports.size() == 0) begin
                $error("result beat for body %0d with nothing expected", o_out_index);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                check_field("out_index", want.idx, o_out_index);
                check_field("new_x", want.x, o_new_x);
                check_field("new_y", want.y, o_new_y);
                check_field("new_vel_x", want.vx, o_new_vel_x);
                check_field("new_vel_y", want.vy, o_new_vel_y);
                check_field("last_body", want.last, o_last_body);
            end
        end
    end

endmodule

`default_nettype wire

// File: swept_box_physics_step.f
rtl/core/sbps_pkg.sv
rtl/core/sbps_pair.sv
rtl/core/swept_box_physics_step.sv
bench/tb_swept_box_physics_step.sv
